// ===== rtl/core/xtea_block_cipher_top_defines.svh =====
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Concurrent assertion helpers shared by the cipher's RTL files. The checks
// drop out when the SYNTHESIS macro is set.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_TOP_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define XBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define XBC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define XBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/core/xbc_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA block cipher package
// Shared constants, register indexes and types for the cipher chain.
// ----------------------------------------------------------------------------
package xbc_pkg;

   localparam int unsigned DEFAULT_ROUNDS = 32;
   localparam int unsigned WORD_W         = 32;
   localparam int unsigned CSR_INDEX_W    = 3;

   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY0      = 3'd0,
      REG_KEY1      = 3'd1,
      REG_KEY2      = 3'd2,
      REG_KEY3      = 3'd3,
      REG_DIRECTION = 3'd4
   } csr_reg_type;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } stage_type;

   typedef logic [3:0][WORD_W-1:0] key_type;

   // Running sum after k delta steps, modulo 2^32.
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned k);
      logic [63:0] product;
      product = 64'(k) * 64'(DELTA);
      return product[WORD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/xbc_round_cell.sv =====
// ----------------------------------------------------------------------------
// XTEA half-round cell
// One half-round of the cipher with its own pipeline register. The running
// sum of this position is a constant for each direction.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_top_defines.svh"

module xbc_round_cell #(
   parameter logic                      FIRST_HALF = 1'b1,
   parameter logic [xbc_pkg::WORD_W-1:0] SUM_ENC   = '0,
   parameter logic [xbc_pkg::WORD_W-1:0] SUM_DEC   = '0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               direction,
   input  xbc_pkg::key_type   key_words,
   input  xbc_pkg::stage_type stage_in,
   output xbc_pkg::stage_type stage_out
);

   logic                       valid_ff, valid_in;
   logic [xbc_pkg::WORD_W-1:0] y_ff, y_in;
   logic [xbc_pkg::WORD_W-1:0] z_ff, z_in;

   logic                       updates_y;
   logic [xbc_pkg::WORD_W-1:0] src, tgt, sum, key, mix, result;
   logic [1:0]                 key_sel;

   // The half that updates y selects its key word by sum bits 1:0, the half
   // that updates z by sum bits 12:11. Deciphering swaps the order.
   always_comb begin
      updates_y = FIRST_HALF ^ direction;
      src       = updates_y ? stage_in.z : stage_in.y;
      tgt       = updates_y ? stage_in.y : stage_in.z;
      sum       = direction ? SUM_DEC : SUM_ENC;
      key_sel   = updates_y ? sum[1:0] : sum[12:11];
      key       = key_words[key_sel];
      mix       = (((src << 4) ^ (src >> 5)) + src) ^ (sum + key);
      result    = direction ? (tgt - mix) : (tgt + mix);
      valid_in  = advance ? stage_in.valid : valid_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      if (advance) begin
         y_in = updates_y ? result : stage_in.y;
         z_in = updates_y ? stage_in.z : result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign stage_out = '{valid: valid_ff, y: y_ff, z: z_ff};

   `XBC_ASSERT_NEXT(a_cell_frozen, clock, reset, !advance, $stable({valid_ff, y_ff, z_ff}), "cell changed while the chain was stalled")
   `XBC_ASSERT_NEXT(a_cell_takes, clock, reset, advance && stage_in.valid, valid_ff, "cell dropped an item")

endmodule

// ===== rtl/core/xtea_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// XTEA block cipher
// Enciphers or deciphers 64-bit blocks under a 128-bit key through a chain
// of half-round cells, one block accepted per clock.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                               Direction  Handshake
//   req      block_first, block_second           in         valid / ready
//   rsp      result_first, result_second         out        valid / ready
//   csr      index, wdata (keys, direction)      in         write enable
//
// Each item passes through 2*ROUNDS cells, one half-round per cell, each
// with its own register. One item is accepted every cycle while the result
// side keeps taking items. The last cell is the output register; when it
// holds a result that is not taken, the whole chain holds and req_ready
// drops. Reset clears the item valid bits of every cell, the key words and
// the direction; keys and direction are read directly by all cells.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_top_defines.svh"

module xtea_block_cipher_top #(
   parameter int unsigned ROUNDS = xbc_pkg::DEFAULT_ROUNDS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [xbc_pkg::WORD_W-1:0]      req_block_first,
   input  logic [xbc_pkg::WORD_W-1:0]      req_block_second,
   // Result items.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [xbc_pkg::WORD_W-1:0]      rsp_result_first,
   output logic [xbc_pkg::WORD_W-1:0]      rsp_result_second,
   // Configuration writes.
   input  logic                            csr_write,
   input  logic [xbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xbc_pkg::WORD_W-1:0]      csr_wdata
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   // Configuration registers. Writes beyond the direction index are dropped.
   xbc_pkg::key_type key_ff, key_in;
   logic             direction_ff, direction_in;

   always_comb begin
      key_in       = key_ff;
      direction_in = direction_ff;
      if (csr_write) begin
         case (xbc_pkg::csr_reg_type'(csr_index))
            xbc_pkg::REG_KEY0:      key_in[0]    = csr_wdata;
            xbc_pkg::REG_KEY1:      key_in[1]    = csr_wdata;
            xbc_pkg::REG_KEY2:      key_in[2]    = csr_wdata;
            xbc_pkg::REG_KEY3:      key_in[3]    = csr_wdata;
            xbc_pkg::REG_DIRECTION: direction_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         direction_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         direction_ff <= direction_in;
      end
   end

   // The chain moves as a whole whenever the output register is free or
   // its result is being taken.
   xbc_pkg::stage_type chain [STAGES+1];
   logic               advance;

   assign advance   = !chain[STAGES].valid || rsp_ready;
   assign req_ready = advance;
   assign chain[0]  = '{valid: req_valid, y: req_block_first, z: req_block_second};

   // Cell 2r and 2r+1 form round r. Enciphering, the even cell updates y
   // with sum r*delta and the odd cell z with (r+1)*delta. Deciphering
   // walks the sums down from ROUNDS*delta, z first.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      localparam int unsigned R     = i / 2;
      localparam logic        EVEN  = (i % 2) == 0;
      localparam int unsigned K_ENC = EVEN ? R : R + 1;
      localparam int unsigned K_DEC = EVEN ? ROUNDS - R : ROUNDS - R - 1;

      xbc_round_cell #(
         .FIRST_HALF (EVEN),
         .SUM_ENC    (xbc_pkg::round_sum(K_ENC)),
         .SUM_DEC    (xbc_pkg::round_sum(K_DEC))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .direction (direction_ff),
         .key_words (key_ff),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign rsp_valid         = chain[STAGES].valid;
   assign rsp_result_first  = chain[STAGES].y;
   assign rsp_result_second = chain[STAGES].z;

   `XBC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, chain[1].valid, "accepted item did not enter the first cell")
   `XBC_ASSERT_NOW(a_held_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "item accepted while a result was held")
   `XBC_ASSERT_NEXT(a_dir_write, clock, reset, csr_write && (csr_index == xbc_pkg::REG_DIRECTION), direction_ff == $past(csr_wdata[0]), "direction write lost")

endmodule

// ===== sim/xtea_block_cipher_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Pushes directed and random 64-bit blocks through the cipher under a series
// of keys and directions, and compares every returned block with a
// behavioral XTEA computed in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module xtea_block_cipher_top_tb;

   typedef logic [xbc_pkg::WORD_W-1:0] word_type;

   typedef struct packed {
      word_type first;
      word_type second;
   } block_type;

   localparam int unsigned ROUNDS     = xbc_pkg::DEFAULT_ROUNDS;
   // Every item walks through one cell per half-round.
   localparam int unsigned LATENCY    = 2 * ROUNDS;
   localparam int unsigned IDLE_PCT   = 21;
   localparam int unsigned CYCLE_CAP  = 400000;
   localparam int unsigned REPORT_CAP = 10;

   // Holds the bench's copy of the key and direction, computes the block
   // that each accepted item must produce and checks results in order.
   class xtea_scoreboard;
      word_type  key[4];
      bit        decipher;
      word_type  decipher_sum;
      block_type expected_blocks[$];
      int        mismatches;

      function new();
         foreach (key[i]) key[i] = '0;
         decipher     = 1'b0;
         mismatches   = 0;
         decipher_sum = '0;
         for (int r = 0; r < ROUNDS; r++) decipher_sum += xbc_pkg::DELTA;
      endfunction

      function void write_reg(logic [xbc_pkg::CSR_INDEX_W-1:0] index, word_type data);
         case (index)
            xbc_pkg::REG_KEY0, xbc_pkg::REG_KEY1,
            xbc_pkg::REG_KEY2, xbc_pkg::REG_KEY3: key[index[1:0]] = data;
            xbc_pkg::REG_DIRECTION: decipher = data[0];
            default: ;
         endcase
      endfunction

      function word_type mix_term(word_type x, word_type sum, word_type key_word);
         return (((x << 4) ^ (x >> 5)) + x) ^ (sum + key_word);
      endfunction

      function block_type cipher_block(word_type y, word_type z);
         word_type  sum;
         block_type out_block;
         if (!decipher) begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++) begin
               y   += mix_term(z, sum, key[sum[1:0]]);
               sum += xbc_pkg::DELTA;
               z   += mix_term(y, sum, key[sum[12:11]]);
            end
         end else begin
            sum = decipher_sum;
            for (int r = 0; r < ROUNDS; r++) begin
               z   -= mix_term(y, sum, key[sum[12:11]]);
               sum -= xbc_pkg::DELTA;
               y   -= mix_term(z, sum, key[sum[1:0]]);
            end
         end
         out_block.first  = y;
         out_block.second = z;
         return out_block;
      endfunction

      function void note_block(word_type y, word_type z);
         expected_blocks.push_back(cipher_block(y, z));
      endfunction

      function void check_result(word_type first, word_type second);
         block_type want;
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("[%0t] unexpected result %h %h", $realtime, first, second);
            return;
         end
         want = expected_blocks.pop_front();
         if (first !== want.first || second !== want.second) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("[%0t] result mismatch: first exp %h got %h, second exp %h got %h",
                        $realtime, want.first, first, want.second, second);
         end
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction
   endclass

   // All block inputs start at known values; reset is held from time zero.
   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_ready;
   word_type                        req_block_first   = '0;
   word_type                        req_block_second  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready         = 1'b0;
   word_type                        rsp_result_first;
   word_type                        rsp_result_second;
   logic                            csr_write         = 1'b0;
   logic [xbc_pkg::CSR_INDEX_W-1:0] csr_index         = '0;
   word_type                        csr_wdata         = '0;

   // Idling switches for the two channels; one random phase turns both off.
   bit send_gaps   = 1'b1;
   bit recv_stalls = 1'b1;

   int unsigned cycle_count = 0;

   xtea_scoreboard cipher_check = new();

   xtea_block_cipher_top #(
      .ROUNDS(ROUNDS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_block_first   (req_block_first),
      .req_block_second  (req_block_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_first  (rsp_result_first),
      .rsp_result_second (rsp_result_second),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The run is cut off if the pipeline ever hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side. Values read right at the edge are those the block saw, so
   // a handshake here is exactly the one the block counted. The ready for
   // the next cycle is then rolled afresh.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         cipher_check.check_result(rsp_result_first, rsp_result_second);
      rsp_ready <= !recv_stalls || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Offers one item and returns in the time step of the edge that took it.
   // A gap, when rolled, lowers valid first, so valid is never dropped and
   // raised again in one step.
   task automatic send_block(input word_type y, input word_type z);
      if (send_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock);
         while (send_gaps && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid        <= 1'b1;
      req_block_first  <= y;
      req_block_second <= z;
      do @(posedge clock);
      while (!req_ready);
      cipher_check.note_block(y, z);
   endtask

   // The sender holds off until every item in flight has come back. Since
   // every item yields exactly one result, an empty queue means the chain
   // is empty and the registers may be rewritten.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (cipher_check.pending() != 0);
   endtask

   // Writes all four key words and the direction, and optionally the unused
   // register indexes above the direction, which must change nothing. The
   // stray writes carry zero so that a wrong decode would clear the key or
   // the direction and show up in the results.
   task automatic apply_config(input word_type k0, input word_type k1, input word_type k2,
                               input word_type k3, input word_type dir_data,
                               input bit stray);
      logic [xbc_pkg::CSR_INDEX_W-1:0] index_list[$];
      word_type                        data_list[$];
      index_list = '{xbc_pkg::REG_KEY0, xbc_pkg::REG_KEY1, xbc_pkg::REG_KEY2,
                     xbc_pkg::REG_KEY3, xbc_pkg::REG_DIRECTION};
      data_list  = '{k0, k1, k2, k3, dir_data};
      if (stray) begin
         for (int i = int'(xbc_pkg::REG_DIRECTION) + 1;
              i < (1 << xbc_pkg::CSR_INDEX_W); i++) begin
            index_list.push_back(xbc_pkg::CSR_INDEX_W'(i));
            data_list.push_back('0);
         end
      end
      foreach (index_list[i]) begin
         csr_write <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
         cipher_check.write_reg(index_list[i], data_list[i]);
      end
      csr_write <= 1'b0;
   endtask

   // Random half-block with the extremes and single set bits mixed in.
   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, xbc_pkg::WORD_W - 1);
         default: return word_type'($urandom);
      endcase
   endfunction

   initial begin
      int phase_len;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Registers straight out of reset: all-zero key, encipher.
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h0000_0000, 32'hFFFF_FFFF);
      send_block(32'hFFFF_FFFF, 32'h0000_0000);
      send_block(32'h8000_0000, 32'h0000_0001);

      // A byte-counting key, enciphered.
      wait_for_results();
      apply_config(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F,
                   32'h0, 1'b0);
      send_block(32'h4142_4344, 32'h4546_4748);
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hDEAD_BEEF, 32'h0123_4567);

      // The same key, deciphered.
      wait_for_results();
      apply_config(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F,
                   32'h1, 1'b0);
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h497D_F3D0, 32'h7261_2CB5);

      // All-ones key and an all-ones direction word: only its low bit counts,
      // so this deciphers. The unused indexes are written as well.
      wait_for_results();
      apply_config('1, '1, '1, '1, 32'hFFFF_FFFF, 1'b1);
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(32'h1234_5678, 32'h9ABC_DEF0);

      // Direction word with every bit but the low one set enciphers.
      wait_for_results();
      apply_config(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFE, 1'b1);
      send_block(32'h0000_0000, 32'h0000_0000);
      send_block(32'hAAAA_AAAA, 32'h5555_5555);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);

      // Random phases, each under its own setting. The first two use the
      // extreme keys; the fourth runs long with neither side idling.
      for (int p = 0; p < 8; p++) begin
         wait_for_results();
         send_gaps   = (p != 3);
         recv_stalls = (p != 3);
         phase_len   = (p == 3) ? 450 : 215;
         if (p == 0)
            apply_config('1, '1, '1, '1, 32'h0, 1'b0);
         else if (p == 1)
            apply_config('0, '0, '0, '0, 32'h1, 1'b1);
         else
            apply_config(random_word(), random_word(), random_word(), random_word(),
                         word_type'($urandom), bit'($urandom_range(0, 1)));
         for (int i = 0; i < phase_len; i++) begin
            // Now and then the sender lets the whole chain empty out.
            if (i == phase_len / 2 || $urandom_range(0, 149) == 0)
               wait_for_results();
            send_block(random_word(), random_word());
         end
      end

      // Everything is in; let the chain empty, then give any stray result
      // a full pass of latency to turn up.
      wait_for_results();
      repeat (LATENCY + 16) @(posedge clock);
      if (cipher_check.mismatches == 0 && cipher_check.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== xtea_block_cipher_top.f =====
+incdir+rtl/core
rtl/core/xbc_pkg.sv
rtl/core/xbc_round_cell.sv
rtl/core/xtea_block_cipher_top.sv
sim/xtea_block_cipher_top_tb.sv
